// ===== hw/rtl/wcp_pkg.sv =====
// Package for the wall column projection block: field widths, fixed-point
// constants and the packed word types of the input and result channels.
// Depends on nothing; every other file of the block uses it.
package wcp_pkg;

    localparam int DIST_W   = 24;
    localparam int DIR_W    = 16;
    localparam int POS_W    = 24;
    localparam int WH_W     = 12;
    localparam int HEIGHT_W = 16;
    localparam int ROW_W    = 12;
    localparam int TEXEL_W  = 6;

    localparam logic [WH_W-1:0] WH_RESET = 12'd480;

    // Texture width in texels, and the widths that follow from it.
    localparam int TEXTURE_WIDTH = 64;
    localparam int TW_W          = $clog2(TEXTURE_WIDTH + 1);
    localparam int TEX_IDX_W     = $clog2(TEXTURE_WIDTH);

    // The hit coordinate is formed in units of 2^-30; position is Q8.16 and
    // the product of distance and direction is Q8.16 * Q2.14, so the position
    // is shifted up by 14 to line the two up.
    localparam int FRAC_BITS = 30;
    localparam int POS_SHIFT = 14;
    localparam int SCALED_W  = FRAC_BITS + TW_W;

    // One quotient bit per divider stage.
    localparam int DIV_STEPS  = HEIGHT_W;
    // Texel path: fraction, scale and mirror stages, then a delay line.
    localparam int TEX_STAGES = 3;
    localparam int TEX_DELAY  = DIV_STEPS - TEX_STAGES;
    // Capture stage, divider stages, row stage.
    localparam int PIPE_DEPTH = DIV_STEPS + 2;

    typedef struct packed {
        logic [DIST_W-1:0]       wall_distance;
        logic                    hit_side;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic [POS_W-1:0]        player_x;
        logic [POS_W-1:0]        player_y;
    } wcp_in_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] slice_height;
        logic [ROW_W-1:0]    first_row;
        logic [ROW_W-1:0]    last_row;
        logic [TEXEL_W-1:0]  texel_column;
    } wcp_out_t;

endpackage

// ===== hw/rtl/wcp_divider.sv =====
// Pipelined restoring divider: window height * 2^16 / distance, one quotient
// bit per stage, with saturation forced from a flag computed ahead of it.
// Depends on wcp_pkg.
module wcp_divider (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [wcp_pkg::DIST_W-1:0]   rem_in,
    input  logic [wcp_pkg::DIST_W-1:0]   divisor_in,
    input  logic                         sat_in,
    output logic [wcp_pkg::HEIGHT_W-1:0] height_out
);

    logic [wcp_pkg::DIST_W-1:0]   rem_reg [wcp_pkg::DIV_STEPS];
    logic [wcp_pkg::DIST_W-1:0]   dsr_reg [wcp_pkg::DIV_STEPS];
    logic [wcp_pkg::HEIGHT_W-1:0] quo_reg [wcp_pkg::DIV_STEPS];
    logic                         sat_reg [wcp_pkg::DIV_STEPS];

    for (genvar k = 0; k < wcp_pkg::DIV_STEPS; k++) begin : g_step
        logic [wcp_pkg::DIST_W-1:0]   prev_rem;
        logic [wcp_pkg::DIST_W-1:0]   prev_dsr;
        logic [wcp_pkg::HEIGHT_W-1:0] prev_quo;
        logic                         prev_sat;
        logic [wcp_pkg::DIST_W:0]     shifted;
        logic                         ge;
        logic [wcp_pkg::DIST_W-1:0]   rem_next;
        logic [wcp_pkg::HEIGHT_W-1:0] quo_next;

        if (k == 0) begin : g_first
            assign prev_rem = rem_in;
            assign prev_dsr = divisor_in;
            assign prev_quo = '0;
            assign prev_sat = sat_in;
        end else begin : g_rest
            assign prev_rem = rem_reg[k-1];
            assign prev_dsr = dsr_reg[k-1];
            assign prev_quo = quo_reg[k-1];
            assign prev_sat = sat_reg[k-1];
        end

        // The low numerator bits are all zero, so each step only doubles.
        always_comb begin
            shifted  = {prev_rem, 1'b0};
            ge       = (shifted >= {1'b0, prev_dsr});
            rem_next = ge ? wcp_pkg::DIST_W'(shifted - {1'b0, prev_dsr})
                          : wcp_pkg::DIST_W'(shifted);
            quo_next = {prev_quo[wcp_pkg::HEIGHT_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                dsr_reg[k] <= prev_dsr;
                quo_reg[k] <= quo_next;
                sat_reg[k] <= prev_sat;
            end
        end
    end

    assign height_out = sat_reg[wcp_pkg::DIV_STEPS-1] ? '1
                                                      : quo_reg[wcp_pkg::DIV_STEPS-1];

endmodule

// ===== hw/rtl/wcp_texel.sv =====
// Texture column path: hit fraction, scaling by the texture width, mirroring,
// then a delay line so that the column lines up with the divider's result.
// Depends on wcp_pkg.
module wcp_texel (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [wcp_pkg::POS_W-1:0]     pos_in,
    input  logic [wcp_pkg::FRAC_BITS-1:0] prod_in,
    input  logic                          mirror_in,
    output logic [wcp_pkg::TEXEL_W-1:0]   texel_out
);

    logic [wcp_pkg::FRAC_BITS-1:0] frac_reg;
    logic                          mirror1_reg;
    logic [wcp_pkg::SCALED_W-1:0]  scaled_reg;
    logic                          mirror2_reg;
    logic [wcp_pkg::TEXEL_W-1:0]   texel_reg [wcp_pkg::TEX_DELAY+1];

    logic [wcp_pkg::FRAC_BITS-1:0] frac_next;
    logic [wcp_pkg::SCALED_W-1:0]  scaled_next;
    logic [wcp_pkg::TEX_IDX_W-1:0] tex_idx;
    logic [wcp_pkg::TEX_IDX_W-1:0] tex_mirrored;
    logic [wcp_pkg::TEXEL_W-1:0]   texel_next;

    always_comb begin
        // Only the fraction matters, so the sum wraps at 2^30 (floor also
        // for negative coordinates).
        frac_next    = wcp_pkg::FRAC_BITS'({pos_in, {wcp_pkg::POS_SHIFT{1'b0}}})
                       + prod_in;
        scaled_next  = wcp_pkg::SCALED_W'(frac_reg)
                       * wcp_pkg::SCALED_W'(wcp_pkg::TEXTURE_WIDTH);
        tex_idx      = scaled_reg[wcp_pkg::FRAC_BITS +: wcp_pkg::TEX_IDX_W];
        tex_mirrored = wcp_pkg::TEX_IDX_W'(wcp_pkg::TEXTURE_WIDTH - 1) - tex_idx;
        texel_next   = mirror2_reg ? wcp_pkg::TEXEL_W'(tex_mirrored)
                                   : wcp_pkg::TEXEL_W'(tex_idx);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            frac_reg     <= frac_next;
            mirror1_reg  <= mirror_in;
            scaled_reg   <= scaled_next;
            mirror2_reg  <= mirror1_reg;
            texel_reg[0] <= texel_next;
        end
    end

    for (genvar k = 1; k <= wcp_pkg::TEX_DELAY; k++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (en) begin
                texel_reg[k] <= texel_reg[k-1];
            end
        end
    end

    assign texel_out = texel_reg[wcp_pkg::TEX_DELAY];

endmodule

// ===== hw/rtl/wall_column_projection.sv =====
// Top level of the wall column projection block: capture stage, divider and
// texel pipelines, row clamping, output skid register and configuration.
// Depends on wcp_pkg, wcp_divider and wcp_texel.
//
// Takes one ray hit per screen column and returns the wall slice: the height
// in rows (window height * 2^16 / distance, truncated, saturating at 65535,
// also for a zero distance), the first and last rows clamped to the window,
// and the texture column. The block is a fixed pipeline of 18 register
// stages: one capture stage holding the direction multiply and the
// saturation compare, sixteen divider stages that each settle one quotient
// bit, and one stage that halves and clamps the rows. While the result side
// does not stall, a word can enter in every cycle, so the sustained rate is
// one word per clock, and each word passes these stages in that order. An
// output skid register parts the two sides: when the result side holds off,
// the last result is parked there and s_ready drops in the next cycle, with
// nothing lost or repeated. The window height is written through the cfg
// port, which is always ready; it resets to 480 and must only be changed
// while no word is in flight.
module wall_column_projection (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  wcp_pkg::wcp_in_t        s_data,

    output logic                    m_valid,
    input  logic                    m_ready,
    output wcp_pkg::wcp_out_t       m_data,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [wcp_pkg::WH_W-1:0] cfg_data
);

    // Configuration register.
    logic [wcp_pkg::WH_W-1:0] window_height_reg;

    // Pipeline control.
    logic                           en;
    logic [wcp_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic [wcp_pkg::PIPE_DEPTH-1:0] valid_next;

    // Capture stage.
    logic [wcp_pkg::DIST_W-1:0]    s1_dist_reg;
    logic                          s1_sat_reg;
    logic [wcp_pkg::POS_W-1:0]     s1_pos_reg;
    logic [wcp_pkg::FRAC_BITS-1:0] s1_prod_reg;
    logic                          s1_mirror_reg;

    logic signed [wcp_pkg::DIR_W-1:0]           dir_sel;
    logic signed [wcp_pkg::DIST_W:0]            dist_signed;
    logic signed [wcp_pkg::DIST_W+wcp_pkg::DIR_W:0] prod_full;
    logic [wcp_pkg::POS_W-1:0]                  pos_sel;
    logic                                       mirror_next;
    logic                                       sat_next;

    // Divider and texel results, aligned with the last divider stage.
    logic [wcp_pkg::HEIGHT_W-1:0] div_height;
    logic [wcp_pkg::TEXEL_W-1:0]  div_texel;

    // Row stage and skid register.
    logic [wcp_pkg::HEIGHT_W-2:0] half_height;
    logic [wcp_pkg::WH_W-2:0]     half_window;
    logic [wcp_pkg::HEIGHT_W-1:0] last_sum;
    wcp_pkg::wcp_out_t            out_next;
    wcp_pkg::wcp_out_t            out_reg;
    wcp_pkg::wcp_out_t            skid_reg;
    logic                         skid_valid_reg;
    logic                         skid_valid_next;
    logic                         out_valid;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_height_reg <= wcp_pkg::WH_RESET;
        end else if (cfg_valid) begin
            window_height_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: the whole pipeline moves unless the skid register
    // already holds a word, so a stall freezes every stage together.
    // ------------------------------------------------------------------
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    assign valid_next = {valid_reg[wcp_pkg::PIPE_DEPTH-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Capture stage: pick the position and direction along the wall, form
    // the distance times direction product and decide saturation. The
    // quotient reaches 2^16 exactly when the window height is at least the
    // distance, and a zero distance saturates as well.
    // ------------------------------------------------------------------
    always_comb begin
        dir_sel     = s_data.hit_side ? s_data.dir_x : s_data.dir_y;
        pos_sel     = s_data.hit_side ? s_data.player_x : s_data.player_y;
        dist_signed = {1'b0, s_data.wall_distance};
        prod_full   = dist_signed * dir_sel;
        // X-side hits looking towards positive x and y-side hits looking
        // towards negative y see the texture from behind.
        mirror_next = s_data.hit_side ? s_data.dir_y[wcp_pkg::DIR_W-1]
                                      : ((s_data.dir_x != '0)
                                         && !s_data.dir_x[wcp_pkg::DIR_W-1]);
        sat_next    = (s_data.wall_distance == '0)
                      || (wcp_pkg::DIST_W'(window_height_reg) >= s_data.wall_distance);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_dist_reg   <= s_data.wall_distance;
            s1_sat_reg    <= sat_next;
            s1_pos_reg    <= pos_sel;
            s1_prod_reg   <= prod_full[wcp_pkg::FRAC_BITS-1:0];
            s1_mirror_reg <= mirror_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider and texture column, both DIV_STEPS stages deep.
    // ------------------------------------------------------------------
    wcp_divider u_divider (
        .aclk       (aclk),
        .en         (en),
        .rem_in     (wcp_pkg::DIST_W'(window_height_reg)),
        .divisor_in (s1_dist_reg),
        .sat_in     (s1_sat_reg),
        .height_out (div_height)
    );

    wcp_texel u_texel (
        .aclk      (aclk),
        .en        (en),
        .pos_in    (s1_pos_reg),
        .prod_in   (s1_prod_reg),
        .mirror_in (s1_mirror_reg),
        .texel_out (div_texel)
    );

    // ------------------------------------------------------------------
    // Row stage: centre the slice on half the window height. The top row
    // stops at zero and the bottom row at the last row of the window; a
    // window height of zero puts both rows at zero.
    // ------------------------------------------------------------------
    always_comb begin
        half_height = div_height[wcp_pkg::HEIGHT_W-1:1];
        half_window = window_height_reg[wcp_pkg::WH_W-1:1];
        last_sum    = wcp_pkg::HEIGHT_W'(half_window) + wcp_pkg::HEIGHT_W'(half_height);

        out_next.slice_height = div_height;
        out_next.texel_column = div_texel;

        if (wcp_pkg::HEIGHT_W'(half_height) > wcp_pkg::HEIGHT_W'(half_window)) begin
            out_next.first_row = '0;
        end else begin
            out_next.first_row = wcp_pkg::ROW_W'(half_window)
                                 - wcp_pkg::ROW_W'(half_height);
        end

        if (window_height_reg == '0) begin
            out_next.last_row = '0;
        end else if (last_sum >= wcp_pkg::HEIGHT_W'(window_height_reg)) begin
            out_next.last_row = wcp_pkg::ROW_W'(window_height_reg - 1'b1);
        end else begin
            out_next.last_row = wcp_pkg::ROW_W'(last_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // Skid register: when the output stage holds a word that is not taken
    // while the pipeline moves on, the word is parked here and goes out
    // first.
    // ------------------------------------------------------------------
    assign out_valid = valid_reg[wcp_pkg::PIPE_DEPTH-1];

    always_comb begin
        if (skid_valid_reg) begin
            skid_valid_next = !m_ready;
        end else begin
            skid_valid_next = out_valid && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!skid_valid_reg) begin
            skid_reg <= out_reg;
        end
    end

    assign m_valid = skid_valid_reg || out_valid;
    assign m_data  = skid_valid_reg ? skid_reg : out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The top row never lies below the bottom row.
    a_rows_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.first_row <= m_data.last_row))
        else $error("first_row beyond last_row");

    // The bottom row stays inside the window.
    a_last_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (window_height_reg != '0))
        |-> (m_data.last_row < window_height_reg))
        else $error("last_row outside the window");

    // While a word is parked in the skid register the pipeline is frozen.
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |=> $stable(valid_reg))
        else $error("pipeline moved while the skid register was full");

    // A parked word is only released when the result side takes it.
    a_skid_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("skid register dropped a word");

endmodule

// ===== tb/wcp_slice_checker.sv =====
// Checker for the wall column projection block: watches the ray, result and
// configuration channels, predicts every wall slice and compares field by field.
// Depends on wcp_pkg for the word types, field widths and fixed-point constants.
module wcp_slice_checker (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  wcp_pkg::wcp_in_t         s_data,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  wcp_pkg::wcp_out_t        m_data,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [wcp_pkg::WH_W-1:0] cfg_data,
    output int                       mismatch_count,
    output int                       open_rays
);
    import wcp_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [WH_W-1:0] window_rows = WH_RESET;
    wcp_out_t        slices_due[$];

    initial begin
        mismatch_count = 0;
        open_rays = 0;
    end

    // Slice height, clamped rows and texture column, mirrored where needed, for one ray.
    function automatic wcp_out_t project_slice(input wcp_in_t ray, input logic [WH_W-1:0] wh);
        logic [63:0] rows, height, half_h, half_w, top, bottom, frac, texel;
        longint      pos, dir, coord;
        logic        mirror;
        wcp_out_t    slice;
        rows = {{(64-WH_W){1'b0}}, wh};
        if (ray.wall_distance == '0) begin
            height = 64'd65535;
        end else begin
            height = (rows << 16) / {{(64-DIST_W){1'b0}}, ray.wall_distance};
            if (height > 64'd65535) begin
                height = 64'd65535;
            end
        end
        half_h = height >> 1;
        half_w = rows >> 1;
        top    = (half_h > half_w) ? 64'd0 : half_w - half_h;
        bottom = half_w + half_h;
        if (rows == 64'd0) begin
            bottom = 64'd0;
        end else if (bottom >= rows) begin
            bottom = rows - 64'd1;
        end

        // Hit coordinate along the wall in units of 2^-30; the low bits of the
        // two's complement sum give the floored fraction for negative values too.
        if (ray.hit_side == 1'b0) begin
            pos = longint'({{(64-POS_W){1'b0}}, ray.player_y});
            dir = longint'($signed(ray.dir_y));
        end else begin
            pos = longint'({{(64-POS_W){1'b0}}, ray.player_x});
            dir = longint'($signed(ray.dir_x));
        end
        coord = (pos <<< POS_SHIFT) + longint'({{(64-DIST_W){1'b0}}, ray.wall_distance}) * dir;
        frac  = {{(64-FRAC_BITS){1'b0}}, coord[FRAC_BITS-1:0]};
        texel = (frac * 64'(TEXTURE_WIDTH)) >> FRAC_BITS;
        if (ray.hit_side == 1'b0) begin
            mirror = (ray.dir_x != '0) && !ray.dir_x[DIR_W-1];
        end else begin
            mirror = ray.dir_y[DIR_W-1];
        end
        if (mirror) begin
            texel = 64'(TEXTURE_WIDTH) - texel - 64'd1;
        end

        slice.slice_height = height[HEIGHT_W-1:0];
        slice.first_row    = top[ROW_W-1:0];
        slice.last_row     = bottom[ROW_W-1:0];
        slice.texel_column = texel[TEXEL_W-1:0];
        return slice;
    endfunction

    always @(posedge aclk) begin : watch
        wcp_out_t want;
        if (!aresetn) begin
            window_rows = WH_RESET;
            slices_due.delete();
        end else begin
            // Results come out at least a pipeline depth after their ray, so the
            // result is checked before a ray taken at the same edge is queued.
            if (m_valid && m_ready) begin
                if (slices_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("%0t: result word with no ray waiting: height %0d first %0d",
                                 $time, m_data.slice_height, m_data.first_row);
                    end
                end else begin
                    want = slices_due.pop_front();
                    if (want.slice_height !== m_data.slice_height ||
                        want.first_row    !== m_data.first_row    ||
                        want.last_row     !== m_data.last_row     ||
                        want.texel_column !== m_data.texel_column) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("%0t: slice expected h %0d rows %0d..%0d tex %0d",
                                     $time, want.slice_height, want.first_row,
                                     want.last_row, want.texel_column);
                            $display("%0t: slice got      h %0d rows %0d..%0d tex %0d",
                                     $time, m_data.slice_height, m_data.first_row,
                                     m_data.last_row, m_data.texel_column);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                slices_due.push_back(project_slice(s_data, window_rows));
            end
            if (cfg_valid && cfg_ready) begin
                window_rows = cfg_data;
            end
        end
        open_rays = slices_due.size();
    end

endmodule

// ===== tb/wall_column_projection_tb.sv =====
// Testbench top for the wall column projection block: clock, reset, ray and
// configuration stimulus, result back-pressure and the final verdict.
// Depends on wcp_pkg, wall_column_projection and wcp_slice_checker.
module wall_column_projection_tb;
    import wcp_pkg::*;

    // Number of random rays in each configuration phase, and the number of
    // phases. Six phases of 67 give roughly four hundred random words.
    localparam int PHASES         = 6;
    localparam int RAYS_PER_PHASE = 67;
    // Length of the long result-side hold, well beyond the pipeline depth so
    // that the block fills up and has to drop s_ready.
    localparam int SQUEEZE_CYCLES = 100;
    // Far above the length of the slowest legal run.
    localparam int CYCLE_LIMIT    = 200000;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    wcp_in_t           s_data;
    logic              m_valid;
    logic              m_ready;
    wcp_out_t          m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [WH_W-1:0]   cfg_data;

    int mismatch_count;
    int open_rays;
    int squeeze_count = 0;
    int cycle_count = 0;

    always #10 aclk = ~aclk;

    wall_column_projection dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    wcp_slice_checker checker_inst (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .open_rays      (open_rays)
    );

    // Watchdog. A hung handshake ends the run here as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic wcp_in_t make_ray(input logic [DIST_W-1:0] distance, input logic side,
                                         input logic [DIR_W-1:0] dx, input logic [DIR_W-1:0] dy,
                                         input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
        wcp_in_t ray;
        ray.wall_distance = distance;
        ray.hit_side      = side;
        ray.dir_x         = dx;
        ray.dir_y         = dy;
        ray.player_x      = px;
        ray.player_y      = py;
        return ray;
    endfunction

    // Offers one ray word and returns at the falling edge after it has been
    // taken. It is entered at a falling edge. In a quiet stretch there is no
    // gap, otherwise valid first stays low for a random gap that may be empty.
    // Valid is only dropped for a gap, so a back-to-back word keeps valid high.
    task automatic send_ray(input wcp_in_t ray, input bit quiet);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ray;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Result side. For every result word it draws a random stall, which may be
    // none and is always none in a quiet stretch. Whenever the stimulus asks for a
    // squeeze it instead holds m_ready low for a long stretch of its own,
    // counted here, while the sender keeps offering rays.
    initial begin : result_sink
        int unsigned stall;
        int          results;
        int          squeezes_done;
        bit          quiet;
        m_ready = 1'b0;
        results = 0;
        squeezes_done = 0;
        quiet = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (results % 40 == 0) begin
                quiet = ($urandom_range(0, 2) == 0);
            end
            if (squeeze_count != squeezes_done) begin
                squeezes_done++;
                stall = SQUEEZE_CYCLES;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 4);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            results++;
        end
    end

    initial begin : stimulus
        wcp_in_t         ray;
        logic [WH_W-1:0] rows;
        int unsigned     pick;
        int              rays_sent;
        bit              quiet;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        rays_sent = 0;
        quiet     = 1'b0;

        // Synchronous reset, released on a falling edge.
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed words at the reset window height of 480 rows. They cover a
        // zero distance, the largest and smallest distances, the border where
        // the height just saturates, a slice taller than the window, every
        // mirroring case on both wall sides, and hit coordinates that go
        // negative so the fraction has to be floored.
        send_ray(make_ray(24'h000000, 1'b0, 16'h0000, 16'h0000, 24'h000000, 24'h000000), 1'b0);
        send_ray(make_ray(24'hFFFFFF, 1'b1, 16'h7FFF, 16'h8000, 24'hFFFFFF, 24'hFFFFFF), 1'b0);
        send_ray(make_ray(24'h000001, 1'b0, 16'h8000, 16'h7FFF, 24'hFFFFFF, 24'h000000), 1'b0);
        send_ray(make_ray(24'h010000, 1'b0, 16'h4000, 16'h4000, 24'h000000, 24'h028000), 1'b0);
        send_ray(make_ray(24'h010000, 1'b0, 16'hC000, 16'h4000, 24'h000000, 24'h028000), 1'b1);
        send_ray(make_ray(24'h010000, 1'b0, 16'h0000, 16'hC000, 24'h000000, 24'h028000), 1'b1);
        send_ray(make_ray(24'h018000, 1'b1, 16'h2000, 16'hC000, 24'h030400, 24'h000000), 1'b0);
        send_ray(make_ray(24'h018000, 1'b1, 16'hE000, 16'h4000, 24'h030400, 24'h000000), 1'b0);
        send_ray(make_ray(24'h018000, 1'b1, 16'h0000, 16'h0000, 24'h030400, 24'h000000), 1'b1);
        send_ray(make_ray(24'h0001E0, 1'b0, 16'h1234, 16'h8765, 24'h111111, 24'h222222), 1'b0);
        send_ray(make_ray(24'h0001E1, 1'b1, 16'h8765, 16'h1234, 24'h333333, 24'h444444), 1'b0);
        send_ray(make_ray(24'h008000, 1'b0, 16'h3FFF, 16'hC001, 24'h7FFFFF, 24'h800000), 1'b0);
        send_ray(make_ray(24'hF00000, 1'b1, 16'hC001, 16'h3FFF, 24'h800000, 24'h7FFFFF), 1'b1);
        send_ray(make_ray(24'h000001, 1'b0, 16'h0001, 16'hFFFF, 24'h000000, 24'h000000), 1'b1);
        send_ray(make_ray(24'h000001, 1'b0, 16'h8000, 16'hFFFF, 24'h000000, 24'h000000), 1'b0);
        send_ray(make_ray(24'h000002, 1'b1, 16'hFFFF, 16'hFFFF, 24'h000000, 24'h000000), 1'b0);
        send_ray(make_ray(24'h123456, 1'b1, 16'h5A5A, 16'hA5A5, 24'hABCDEF, 24'h654321), 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            // The window height may only change with nothing in flight, so
            // wait until every expected slice has come back.
            s_valid <= 1'b0;
            while (open_rays != 0) @(negedge aclk);
            case (phase)
                0:       rows = 12'd4095;
                1:       rows = 12'd1;
                2:       rows = 12'd0;
                3:       rows = 12'd640;
                default: rows = 12'($urandom_range(2, 4094));
            endcase
            cfg_valid <= 1'b1;
            cfg_data  <= rows;
            do @(posedge aclk); while (!(cfg_valid && cfg_ready));
            @(negedge aclk);
            cfg_valid <= 1'b0;

            // Two phases carry a long result-side hold near their start.
            if (phase == 1 || phase == 4) begin
                squeeze_count <= squeeze_count + 1;
            end

            for (int i = 0; i < RAYS_PER_PHASE; i++) begin
                if (rays_sent % 32 == 0) begin
                    quiet = ($urandom_range(0, 2) == 0);
                end
                // Distances lean towards the range of a real scene, with a
                // share of very short ones that can saturate the height, some
                // zeros and some anywhere in the full field.
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       ray.wall_distance = '0;
                    1:       ray.wall_distance = DIST_W'($urandom_range(1, 1023));
                    7, 8, 9: ray.wall_distance = DIST_W'($urandom);
                    default: ray.wall_distance = DIST_W'($urandom_range(24'h004000, 24'h0A0000));
                endcase
                ray.hit_side = 1'($urandom);
                ray.dir_x    = DIR_W'($urandom);
                ray.dir_y    = DIR_W'($urandom);
                // Now and then an axis-aligned or extreme direction component.
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       ray.dir_x = 16'h0000;
                        1:       ray.dir_y = 16'h0000;
                        2:       ray.dir_x = 16'h8000;
                        default: ray.dir_y = 16'h7FFF;
                    endcase
                end
                ray.player_x = POS_W'($urandom);
                ray.player_y = POS_W'($urandom);
                send_ray(ray, quiet);
                rays_sent++;
            end
        end
        s_valid <= 1'b0;

        // Let every slice come back, then give a stray extra word time to
        // show itself before the verdict.
        while (open_rays != 0) @(negedge aclk);
        repeat (PIPE_DEPTH + 8) @(negedge aclk);

        if (mismatch_count == 0 && open_rays == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
